// File: sv/asam_pkg.sv
// asam_pkg: types, codes and default constants of the aligned stack allocator
// with rollback marker; used by every module of the block, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package asam_pkg;

    localparam int C_OFFSET_BITS    = 24;
    localparam int C_MAX_ALIGN_LOG2 = 12;
    localparam int C_STAT_BITS      = 32;

    localparam int C_SIZE_W  = 25;
    localparam int C_ALIGN_W = 4;
    localparam int C_STAT_W  = 32;
    localparam int C_ALOG_W  = 5;
    localparam int C_ADDR_W  = 3;
    localparam int C_DATA_W  = 32;

    localparam logic [C_SIZE_W-1:0] C_POOL_RESET = 25'h100_0000;

    localparam logic [0:0] C_REG_POOL = 1'b0;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FLUSH    = 2'd1,
        CMD_MARK     = 2'd2,
        CMD_ROLLBACK = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NO_MARKER = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                   cmd;
        logic [C_SIZE_W-1:0]    req_size;
        logic [C_ALIGN_W-1:0]   align_log2;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [C_SIZE_W-1:0]    alloc_offset;
        logic [C_SIZE_W-1:0]    space_left;
        logic [C_SIZE_W-1:0]    largest_alloc;
        logic [C_STAT_W-1:0]    used_since_flush;
        logic [C_STAT_W-1:0]    peak_used;
        logic [C_STAT_W-1:0]    alloc_total;
    } t_out_item;

endpackage

`default_nettype wire

// File: sv/asam_calc.sv
// asam_calc: combinational command datapath, align-up, fit check, statistics
// and the result item; depends on asam_pkg
`timescale 1ns / 1ps
`default_nettype none

module asam_calc #(
    parameter int OFFSET_BITS    = asam_pkg::C_OFFSET_BITS,
    parameter int MAX_ALIGN_LOG2 = asam_pkg::C_MAX_ALIGN_LOG2,
    parameter int STAT_BITS      = asam_pkg::C_STAT_BITS
) (
    input  asam_pkg::t_in_item                  i_item,
    input  logic [asam_pkg::C_SIZE_W-1:0]       i_pool,
    input  logic [OFFSET_BITS:0]                i_top,
    input  logic [OFFSET_BITS:0]                i_mark,
    input  logic                                i_mark_vld,
    input  logic [STAT_BITS-1:0]                i_used,
    input  logic [STAT_BITS-1:0]                i_peak,
    input  logic [OFFSET_BITS:0]                i_largest,
    input  logic [STAT_BITS-1:0]                i_count,
    output logic [OFFSET_BITS:0]                o_top,
    output logic [OFFSET_BITS:0]                o_mark,
    output logic                                o_mark_vld,
    output logic [STAT_BITS-1:0]                o_used,
    output logic [STAT_BITS-1:0]                o_peak,
    output logic [OFFSET_BITS:0]                o_largest,
    output logic [STAT_BITS-1:0]                o_count,
    output asam_pkg::t_out_item                 o_item
);
    import asam_pkg::*;

    localparam int OW  = OFFSET_BITS + 1;
    localparam int M1  = (OW > MAX_ALIGN_LOG2 + 1) ? OW : MAX_ALIGN_LOG2 + 1;
    localparam int EW  = ((M1 > C_SIZE_W) ? M1 : C_SIZE_W) + 2;
    localparam int SW  = ((STAT_BITS > EW) ? STAT_BITS : EW) + 1;
    localparam int PW  = (OW > C_SIZE_W) ? OW : C_SIZE_W;

    logic [PW-1:0]       pool_wide;
    logic [PW-1:0]       pool_cap;
    logic [OW-1:0]       pool_eff;
    logic [C_ALOG_W-1:0] alog;
    logic [EW-1:0]       mask;
    logic [EW-1:0]       aligned;
    logic [EW-1:0]       end_off;
    logic [EW-1:0]       taken;
    logic                fits;
    logic [SW-1:0]       used_sum;
    logic [SW-1:0]       stat_max;
    t_status             status;
    logic [EW-1:0]       granted;

    // effective pool is capped at the offset range
    assign pool_wide = PW'(i_pool);
    assign pool_cap  = PW'(1) << OFFSET_BITS;
    assign pool_eff  = (pool_wide > pool_cap) ? OW'(pool_cap) : OW'(pool_wide);

    assign alog = (C_ALOG_W'(i_item.align_log2) > C_ALOG_W'(MAX_ALIGN_LOG2))
                  ? C_ALOG_W'(MAX_ALIGN_LOG2) : C_ALOG_W'(i_item.align_log2);
    assign mask     = (EW'(1) << alog) - EW'(1);
    assign aligned  = (EW'(i_top) + mask) & ~mask;
    assign end_off  = aligned + EW'(i_item.req_size);
    assign fits     = end_off <= EW'(pool_eff);
    assign taken    = end_off - EW'(i_top);
    assign stat_max = SW'({STAT_BITS{1'b1}});
    assign used_sum = SW'(i_used) + SW'(taken);

    always_comb begin
        o_top      = i_top;
        o_mark     = i_mark;
        o_mark_vld = i_mark_vld;
        o_used     = i_used;
        o_peak     = i_peak;
        o_largest  = i_largest;
        o_count    = i_count;
        status     = ST_OK;
        granted    = '0;
        unique case (i_item.cmd)
            CMD_ALLOC: begin
                if (!fits) begin
                    status = ST_NO_SPACE;
                end else begin
                    granted = aligned;
                    o_top   = OW'(end_off);
                    o_used  = (used_sum > stat_max) ? {STAT_BITS{1'b1}}
                                                    : STAT_BITS'(used_sum);
                    o_count = (&i_count) ? i_count : i_count + STAT_BITS'(1);
                    if (taken > EW'(i_largest)) begin
                        o_largest = OW'(taken);
                    end
                end
            end
            CMD_FLUSH: begin
                o_top      = '0;
                o_peak     = (i_used > i_peak) ? i_used : i_peak;
                o_used     = '0;
                o_mark     = '0;
                o_mark_vld = 1'b0;
            end
            CMD_MARK: begin
                o_mark     = i_top;
                o_mark_vld = 1'b1;
            end
            CMD_ROLLBACK: begin
                if (!i_mark_vld) begin
                    status = ST_NO_MARKER;
                end else begin
                    o_top = i_mark;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_comb begin
        o_item.status           = status;
        o_item.alloc_offset     = C_SIZE_W'(granted);
        o_item.space_left       = (pool_eff > o_top) ? C_SIZE_W'(pool_eff - o_top) : '0;
        o_item.largest_alloc    = C_SIZE_W'(o_largest);
        o_item.used_since_flush = C_STAT_W'(o_used);
        o_item.peak_used        = C_STAT_W'(o_peak);
        o_item.alloc_total      = C_STAT_W'(o_count);
    end

endmodule

`default_nettype wire

// File: sv/aligned_stack_allocator_marker.sv
// aligned_stack_allocator_marker: top level, apb pool register, input and
// result registers, allocator state; depends on asam_pkg and asam_calc
//
// Usage:
//   Commands enter on the in channel (i_in_valid / o_in_ready, i_in_item) and
//   each one gives exactly one result item on the out channel (o_out_valid /
//   i_out_ready, o_out_item). An item is taken into the input register, is
//   processed in one pass of combinational logic against the allocator state
//   and lands in the result register once that is free, raising o_out_valid.
//   One item per cycle is sustained while the receiver does not stall;
//   the figure is set by the single align, add and compare of the alloc path.
//   While the receiver stalls, the result register holds and one more item
//   is still taken into the input register; then o_in_ready drops.
//   The pool size register (address 0) is written over the apb port only
//   while the block is idle, a user rule the block does not enforce; pready
//   is always high, reads with paddr[2] clear return the pool size and other
//   reads return zero. Synchronous active-low reset empties both registers,
//   restores the full pool size and clears the top, marker and all statistics.
`timescale 1ns / 1ps
`default_nettype none

module aligned_stack_allocator_marker #(
    parameter int OFFSET_BITS    = asam_pkg::C_OFFSET_BITS,
    parameter int MAX_ALIGN_LOG2 = asam_pkg::C_MAX_ALIGN_LOG2,
    parameter int STAT_BITS      = asam_pkg::C_STAT_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [asam_pkg::C_ADDR_W-1:0]   paddr,
    input  logic [asam_pkg::C_DATA_W-1:0]   pwdata,
    output logic [asam_pkg::C_DATA_W-1:0]   prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  asam_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output asam_pkg::t_out_item             o_out_item
);
    import asam_pkg::*;

    logic [C_SIZE_W-1:0]  r_pool;
    logic                 r_in_vld;
    t_in_item             r_in;
    logic                 r_out_vld;
    t_out_item            r_out;
    logic [OFFSET_BITS:0] r_top;
    logic [OFFSET_BITS:0] r_mark;
    logic                 r_mark_vld;
    logic [STAT_BITS-1:0] r_used;
    logic [STAT_BITS-1:0] r_peak;
    logic [OFFSET_BITS:0] r_largest;
    logic [STAT_BITS-1:0] r_count;

    logic [OFFSET_BITS:0] n_top;
    logic [OFFSET_BITS:0] n_mark;
    logic                 n_mark_vld;
    logic [STAT_BITS-1:0] n_used;
    logic [STAT_BITS-1:0] n_peak;
    logic [OFFSET_BITS:0] n_largest;
    logic [STAT_BITS-1:0] n_count;
    t_out_item            n_out;

    logic advance;
    logic cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[C_ADDR_W-1] == C_REG_POOL) ? C_DATA_W'(r_pool) : '0;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    asam_calc #(
        .OFFSET_BITS    (OFFSET_BITS),
        .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2),
        .STAT_BITS      (STAT_BITS)
    ) u_calc (
        .i_item     (r_in),
        .i_pool     (r_pool),
        .i_top      (r_top),
        .i_mark     (r_mark),
        .i_mark_vld (r_mark_vld),
        .i_used     (r_used),
        .i_peak     (r_peak),
        .i_largest  (r_largest),
        .i_count    (r_count),
        .o_top      (n_top),
        .o_mark     (n_mark),
        .o_mark_vld (n_mark_vld),
        .o_used     (n_used),
        .o_peak     (n_peak),
        .o_largest  (n_largest),
        .o_count    (n_count),
        .o_item     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= C_POOL_RESET;
        end else if (cfg_wr && paddr[C_ADDR_W-1] == C_REG_POOL) begin
            r_pool <= C_SIZE_W'(pwdata);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // result register and allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_top      <= '0;
            r_mark     <= '0;
            r_mark_vld <= 1'b0;
            r_used     <= '0;
            r_peak     <= '0;
            r_largest  <= '0;
            r_count    <= '0;
        end else if (advance) begin
            r_out_vld  <= 1'b1;
            r_top      <= n_top;
            r_mark     <= n_mark;
            r_mark_vld <= n_mark_vld;
            r_used     <= n_used;
            r_peak     <= n_peak;
            r_largest  <= n_largest;
            r_count    <= n_count;
        end else if (i_out_ready) begin
            r_out_vld  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: sv/asam_checker.sv
// asam_checker: port-level assertions for the allocator top level, bound in
// below; depends on asam_pkg and aligned_stack_allocator_marker
`timescale 1ns / 1ps
`default_nettype none

module asam_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  asam_pkg::t_out_item             o_out_item
);
    import asam_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // an empty result side never blocks the input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with no result pending");

    // a granted offset only comes with an ok status
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.alloc_offset != '0 |-> o_out_item.status == ST_OK)
        else $error("nonzero offset on a failed command");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind aligned_stack_allocator_marker asam_checker u_asam_checker (.*);

`default_nettype wire

// File: dv/tb_aligned_stack_allocator_marker.sv
// tb_aligned_stack_allocator_marker: self-checking bench for the aligned stack allocator,
// with an in-bench predictor, apb pool writes, random idling and an output stall
// depends on asam_pkg and aligned_stack_allocator_marker
`timescale 1ns / 1ps

module tb_aligned_stack_allocator_marker;
    import asam_pkg::*;

    localparam logic [63:0] POOL_CAP = 64'd1 << C_OFFSET_BITS;
    localparam logic [63:0] STAT_MAX = (64'd1 << C_STAT_BITS) - 64'd1;
    localparam logic [C_ADDR_W-1:0] POOL_ADDR = C_ADDR_W'(4 * C_REG_POOL);
    localparam logic [C_SIZE_W-1:0] SIZE_ALL_ONES = '1;
    localparam int QUIET_LIMIT = 2000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [C_ADDR_W-1:0]    paddr;
    logic [C_DATA_W-1:0]    pwdata;
    logic [C_DATA_W-1:0]    prdata;
    logic                   pready;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_item               i_in_item;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out_item              o_out_item;

    // allocator state as the bench sees it
    logic [C_SIZE_W-1:0]    pool_reg = C_POOL_RESET;
    logic [C_SIZE_W-1:0]    top_q = '0;
    logic [C_SIZE_W-1:0]    mark_q = '0;
    logic                   mark_ok = 1'b0;
    logic [C_STAT_W-1:0]    used_q = '0;
    logic [C_STAT_W-1:0]    peak_q = '0;
    logic [C_SIZE_W-1:0]    largest_q = '0;
    logic [C_STAT_W-1:0]    grants_q = '0;

    t_out_item              expected_results[$];
    int                     errors = 0;
    int                     results_seen = 0;
    int                     quiet = 0;
    int                     hold_cycles = 0;
    bit                     in_idle = 1'b1;
    bit                     out_idle = 1'b1;

    aligned_stack_allocator_marker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (errors < 50) begin
            $display("mismatch: %s", msg);
        end
        errors++;
    endtask

    function automatic logic [C_STAT_W-1:0] sat_stat(input logic [C_STAT_W-1:0] a,
                                                     input logic [63:0] b);
        logic [63:0] s;
        s = 64'(a) + b;
        return (s > STAT_MAX) ? C_STAT_W'(STAT_MAX) : s[C_STAT_W-1:0];
    endfunction

    function automatic t_out_item predict_command(input t_in_item it);
        t_out_item   r;
        logic [63:0] pool_eff;
        logic [63:0] step;
        logic [63:0] aligned;
        logic [63:0] fin;
        logic [63:0] taken;
        int          alog;
        r = '0;
        r.status = ST_OK;
        pool_eff = (64'(pool_reg) > POOL_CAP) ? POOL_CAP : 64'(pool_reg);
        case (it.cmd)
            CMD_ALLOC: begin
                alog = (it.align_log2 > C_MAX_ALIGN_LOG2) ? C_MAX_ALIGN_LOG2 : it.align_log2;
                step = 64'd1 << alog;
                aligned = (64'(top_q) + step - 64'd1) & ~(step - 64'd1);
                fin = aligned + 64'(it.req_size);
                if (fin > pool_eff) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    taken = fin - 64'(top_q);
                    r.alloc_offset = aligned[C_SIZE_W-1:0];
                    top_q = fin[C_SIZE_W-1:0];
                    used_q = sat_stat(used_q, taken);
                    grants_q = sat_stat(grants_q, 64'd1);
                    if (taken > 64'(largest_q)) begin
                        largest_q = taken[C_SIZE_W-1:0];
                    end
                end
            end
            CMD_FLUSH: begin
                top_q = '0;
                if (used_q > peak_q) begin
                    peak_q = used_q;
                end
                used_q = '0;
                mark_q = '0;
                mark_ok = 1'b0;
            end
            CMD_MARK: begin
                mark_q = top_q;
                mark_ok = 1'b1;
            end
            default: begin
                if (!mark_ok) begin
                    r.status = ST_NO_MARKER;
                end else begin
                    top_q = mark_q;
                end
            end
        endcase
        r.space_left = (pool_eff > 64'(top_q)) ? C_SIZE_W'(pool_eff - 64'(top_q)) : '0;
        r.largest_alloc = largest_q;
        r.used_since_flush = used_q;
        r.peak_used = peak_q;
        r.alloc_total = grants_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp);
        if (got !== exp) begin
            report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                      results_seen, name, got, exp));
        end
    endtask

    task automatic compare_result(input t_out_item got, input t_out_item exp);
        check_field("status", got.status, exp.status);
        check_field("alloc_offset", got.alloc_offset, exp.alloc_offset);
        check_field("space_left", got.space_left, exp.space_left);
        check_field("largest_alloc", got.largest_alloc, exp.largest_alloc);
        check_field("used_since_flush", got.used_since_flush, exp.used_since_flush);
        check_field("peak_used", got.peak_used, exp.peak_used);
        check_field("alloc_total", got.alloc_total, exp.alloc_total);
    endtask

    // predict on input handshakes, check on output handshakes
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_results = {expected_results, predict_command(i_in_item)};
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no item pending",
                                          results_seen));
            end else begin
                compare_result(o_out_item, expected_results.pop_front());
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = out_idle ? $urandom_range(0, 16) : 0;
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(input t_in_item it);
        int gap;
        gap = in_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_pool(input logic [C_SIZE_W-1:0] value);
        logic [C_DATA_W-1:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= POOL_ADDR;
        pwdata <= C_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pool_reg = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== C_DATA_W'(value)) begin
            report_mismatch($sformatf("pool readback: got %0h expected %0h", readback, value));
        end
    endtask

    // size and alignment are don't-care for non-alloc commands, so they get noise
    function automatic t_in_item cmd_item(input t_cmd c, input logic [C_SIZE_W-1:0] size,
                                          input logic [C_ALIGN_W-1:0] alog);
        t_in_item it;
        it.cmd = c;
        it.req_size = (c == CMD_ALLOC) ? size : C_SIZE_W'($urandom);
        it.align_log2 = (c == CMD_ALLOC) ? alog : C_ALIGN_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it.req_size = C_SIZE_W'($urandom);
        it.align_log2 = C_ALIGN_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            it.cmd = CMD_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                it.req_size = C_SIZE_W'($urandom_range(0, 65536));
            end else if (pick < 23) begin
                it.req_size = '0;
            end else if (pick >= 33) begin
                it.req_size = C_SIZE_W'($urandom_range(0, 300));
            end
        end else if (pick < 74) begin
            it.cmd = CMD_MARK;
        end else if (pick < 88) begin
            it.cmd = CMD_ROLLBACK;
        end else begin
            it.cmd = CMD_FLUSH;
        end
        return it;
    endfunction

    task automatic test_directed_cases();
        send_item(cmd_item(CMD_ROLLBACK, '0, '0));
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd1, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd3, 4'd4));
        send_item(cmd_item(CMD_ALLOC, 25'd5, 4'd15));
        send_item(cmd_item(CMD_ALLOC, 25'd100, 4'd12));
        send_item(cmd_item(CMD_MARK, '0, '0));
        send_item(cmd_item(CMD_ALLOC, SIZE_ALL_ONES, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'h100_0000, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd1000, 4'd3));
        send_item(cmd_item(CMD_ROLLBACK, '0, '0));
        send_item(cmd_item(CMD_ROLLBACK, '0, '0));
        send_item(cmd_item(CMD_FLUSH, '0, '0));
        send_item(cmd_item(CMD_ROLLBACK, '0, '0));
        send_item(cmd_item(CMD_ALLOC, 25'h100_0000, 4'd12));
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd13));
        send_item(cmd_item(CMD_ALLOC, 25'd1, 4'd0));
        send_item(cmd_item(CMD_MARK, '0, '0));
        send_item(cmd_item(CMD_FLUSH, '0, '0));
        send_item(cmd_item(CMD_ALLOC, 25'h0AA_AAAA, 4'd9));
        send_item(cmd_item(CMD_ALLOC, 25'h155_5555, 4'd6));
        send_item(cmd_item(CMD_FLUSH, '0, '0));
        wait_results_done();
    endtask

    task automatic test_pool_settings();
        write_pool(25'd1);
        send_item(cmd_item(CMD_ALLOC, 25'd1, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd1, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd1));
        send_item(cmd_item(CMD_FLUSH, '0, '0));
        wait_results_done();
        write_pool(25'd0);
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd1, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd12));
        send_item(cmd_item(CMD_FLUSH, '0, '0));
        wait_results_done();
        write_pool(SIZE_ALL_ONES);
        send_item(cmd_item(CMD_ALLOC, 25'h100_0000, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd0));
        send_item(cmd_item(CMD_ALLOC, 25'd1, 4'd0));
        send_item(cmd_item(CMD_FLUSH, '0, '0));
        wait_results_done();
        write_pool(C_POOL_RESET);
        send_item(cmd_item(CMD_ALLOC, 25'd5000, 4'd0));
        send_item(cmd_item(CMD_MARK, '0, '0));
        wait_results_done();
        // pool shrinks below the current top
        write_pool(25'd100);
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd0));
        send_item(cmd_item(CMD_ROLLBACK, '0, '0));
        send_item(cmd_item(CMD_FLUSH, '0, '0));
        send_item(cmd_item(CMD_ALLOC, 25'd100, 4'd2));
        send_item(cmd_item(CMD_ALLOC, 25'd0, 4'd0));
        wait_results_done();
        write_pool(25'd4096);
        repeat (20) send_item(random_item());
        wait_results_done();
    endtask

    // rollback lets the same full-pool grant be counted again until the sum saturates
    task automatic test_used_saturation();
        write_pool(C_POOL_RESET);
        send_item(cmd_item(CMD_FLUSH, '0, '0));
        send_item(cmd_item(CMD_MARK, '0, '0));
        repeat (260) begin
            send_item(cmd_item(CMD_ALLOC, 25'h100_0000, C_ALIGN_W'($urandom)));
            send_item(cmd_item(CMD_ROLLBACK, '0, '0));
        end
        send_item(cmd_item(CMD_FLUSH, '0, '0));
        send_item(cmd_item(CMD_ALLOC, 25'd10, 4'd0));
        wait_results_done();
    endtask

    task automatic test_output_stall();
        in_idle = 1'b0;
        hold_cycles = 150;
        repeat (40) send_item(random_item());
        wait_results_done();
        in_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        repeat (12) begin
            wait_results_done();
            case ($urandom_range(0, 5))
                0: write_pool(C_POOL_RESET);
                1: write_pool(SIZE_ALL_ONES);
                2: write_pool('0);
                3: write_pool(C_SIZE_W'($urandom_range(1, 4096)));
                4: write_pool(C_SIZE_W'($urandom_range(1, 1 << 20)));
                default: write_pool(C_SIZE_W'($urandom));
            endcase
            in_idle = ($urandom_range(0, 2) != 0);
            out_idle = ($urandom_range(0, 2) != 0);
            repeat (50) send_item(random_item());
        end
        wait_results_done();
        in_idle = 1'b1;
        out_idle = 1'b1;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_pool_settings();
        test_used_saturation();
        test_output_stall();
        test_random_traffic();
        wait_results_done();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: aligned_stack_allocator_marker.f
sv/asam_pkg.sv
sv/asam_calc.sv
sv/aligned_stack_allocator_marker.sv
sv/asam_checker.sv
dv/tb_aligned_stack_allocator_marker.sv
